[rtl/core/rbe_pkg.sv]
package rbe_pkg;

	// Table geometry
	localparam int NUM_CONTEXTS = 64;
	localparam int CTX_W        = 6;
	localparam int SYM_W        = 8;
	localparam int SYMS         = 1 << SYM_W;
	localparam int TBL_DEPTH    = NUM_CONTEXTS * SYMS;
	localparam int TBL_AW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	// Coder arithmetic
	localparam int PROB_BITS    = 14;
	localparam int FREQ_W       = 14;
	localparam int SUM_W        = 15;
	localparam int STATE_W      = 32;
	localparam int BYTE_W       = 8;
	localparam int LB_LOG2      = 23;
	localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LB_LOG2;

	// renorm bound = f << RENORM_SHIFT
	localparam int RENORM_SHIFT = LB_LOG2 - PROB_BITS + BYTE_W;
	localparam int BOUND_W      = FREQ_W + RENORM_SHIFT;
	localparam int CMP_W        = (BOUND_W > STATE_W) ? BOUND_W : STATE_W;
	localparam int MAX_RENORM   = 2;

	// radix-4 long division, one quotient digit per cycle
	localparam int DIGIT_W      = 2;
	localparam int DIV_STEPS    = STATE_W / DIGIT_W;
	localparam int PART_W       = FREQ_W + DIGIT_W;
	localparam int FLUSH_BYTES  = STATE_W / BYTE_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_RENORM,
		ST_DIV,
		ST_FIX,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [SUM_W-1:0]  cum;
	} rbe_entry_t;

	typedef struct packed {
		logic              load;
		logic              lookup;
		logic [CTX_W-1:0]  ctx;
		logic [SYM_W-1:0]  sym;
		logic [FREQ_W-1:0] freq;
	} rbe_tbl_req_t;

endpackage

[rtl/core/rbe_if.sv]
interface rbe_cmd_if;
	import rbe_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [CTX_W-1:0]  context_req;
	logic [SYM_W-1:0]  symbol;
	logic [FREQ_W-1:0] frequency;

	modport source (output valid, output operation, output context_req, output symbol,
		output frequency, input ready);
	modport sink (input valid, input operation, input context_req, input symbol,
		input frequency, output ready);
endinterface

interface rbe_res_if;
	import rbe_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_valid;
	logic              error;
	logic              last;

	modport source (output valid, output out_byte, output byte_valid, output error,
		output last, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input error,
		input last, output ready);
endinterface

[rtl/core/rbe_table.sv]
module rbe_table import rbe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rbe_tbl_req_t req,
	output rbe_entry_t   entry
);

	rbe_entry_t         tbl_mem [TBL_DEPTH];
	rbe_entry_t         entry_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_base;
	logic [TBL_AW-1:0]  addr;

	assign addr     = TBL_AW'({req.ctx, req.sym});
	// running sum restarts at symbol 0
	assign sum_base = (req.sym == '0) ? '0 : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (req.load) begin
			sum_q <= sum_base + SUM_W'(req.freq);
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			tbl_mem[addr] <= '{freq: req.freq, cum: sum_base};
		end
		if (req.lookup) begin
			entry_q <= tbl_mem[addr];
		end
	end

	assign entry = entry_q;

endmodule

[rtl/core/rans_byte_encoder.sv]
// Load: no result beat; the next command is taken right after.
// Encode: the table read is registered (ST_LOOKUP), then ST_RENORM writes the result beats;
//   the next command is taken back in ST_IDLE after the radix-4 divider (ST_DIV) and the state
//   update (ST_FIX), plus result stalls; an error beat returns to ST_IDLE without the divider.
// Flush: four byte beats on consecutive cycles while the result channel does not stall, then the state returns to 2^23.
// Reset (arst_n low, asynchronous): coder state 2^23, running sum 0; tables are not cleared.
module rans_byte_encoder import rbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rbe_cmd_if.sink   cmd,
	rbe_res_if.source result
);

	state_t               state_q, state_d;
	logic [STATE_W-1:0]   st_q, st_d;       // coder state / dividend-quotient shifter
	logic [FREQ_W-1:0]    rem_q, rem_d;     // partial remainder
	logic [CNT_W-1:0]     cnt_q, cnt_d;     // byte / digit counter
	logic                 ctx_ok_q, ctx_ok_d;

	// result beat register
	logic                 res_valid_q;
	logic [BYTE_W-1:0]    res_byte_q;
	logic                 res_bv_q, res_err_q, res_last_q;
	logic                 out_free;

	logic                 emit;
	logic [BYTE_W-1:0]    emit_byte;
	logic                 emit_bv, emit_err, emit_last;

	rbe_tbl_req_t         tbl_req;
	rbe_entry_t           entry;

	logic                 accept;
	logic                 cmd_ctx_ok;

	// renormalization compare
	logic [CMP_W-1:0]     bound;
	logic                 ge_cur, ge_next;

	// divider step
	logic [PART_W-1:0]    part, f1, f2, f3, sub;
	logic [DIGIT_W-1:0]   digit;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd_ctx_ok = (32'(cmd.context_req) < NUM_CONTEXTS);
	assign out_free   = !res_valid_q || result.ready;

	assign tbl_req.load   = accept && (op_t'(cmd.operation) == OP_LOAD) && cmd_ctx_ok;
	assign tbl_req.lookup = accept && (op_t'(cmd.operation) == OP_ENCODE);
	assign tbl_req.ctx    = cmd.context_req;
	assign tbl_req.sym    = cmd.symbol;
	assign tbl_req.freq   = cmd.frequency;

	rbe_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.entry  (entry)
	);

	// Emit while x >= (2^23 >> PROB_BITS << 8) * f, at most two bytes.
	assign bound   = CMP_W'(entry.freq) << RENORM_SHIFT;
	assign ge_cur  = CMP_W'(st_q) >= bound;
	assign ge_next = CMP_W'(st_q >> BYTE_W) >= bound;

	// One radix-4 digit: remainder stays below f, so the partial is below 4f.
	assign part = {rem_q, st_q[STATE_W-1 -: DIGIT_W]};
	assign f1   = PART_W'(entry.freq);
	assign f2   = f1 << 1;
	assign f3   = f1 + f2;

	always_comb begin
		priority if (part >= f3) begin
			digit = 2'd3;
			sub   = f3;
		end else if (part >= f2) begin
			digit = 2'd2;
			sub   = f2;
		end else if (part >= f1) begin
			digit = 2'd1;
			sub   = f1;
		end else begin
			digit = 2'd0;
			sub   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			st_q     <= LOWER_BOUND;
			cnt_q    <= '0;
			ctx_ok_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			st_q     <= st_d;
			cnt_q    <= cnt_d;
			ctx_ok_q <= ctx_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
	end

	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		ctx_ok_d  = ctx_ok_q;
		emit      = 1'b0;
		emit_byte = '0;
		emit_bv   = 1'b0;
		emit_err  = 1'b0;
		emit_last = 1'b0;
		cmd.ready = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (accept) begin
					cnt_d = '0;
					unique case (op_t'(cmd.operation))
						OP_ENCODE: begin
							state_d  = ST_LOOKUP;
							ctx_ok_d = cmd_ctx_ok;
						end
						OP_FLUSH:  state_d = ST_FLUSH;
						OP_LOAD:   state_d = ST_IDLE;
						OP_NONE:   state_d = ST_IDLE;
					endcase
				end
			end

			ST_LOOKUP: begin
				state_d = ST_RENORM;
			end

			ST_RENORM: begin
				if (out_free) begin
					emit = 1'b1;
					priority if (!ctx_ok_q || entry.freq == '0) begin
						// unusable symbol: flag it, state untouched
						emit_err  = 1'b1;
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end else if (ge_cur && cnt_q < CNT_W'(MAX_RENORM)) begin
						emit_byte = st_q[BYTE_W-1:0];
						emit_bv   = 1'b1;
						emit_last = !(cnt_q == '0 && ge_next);
						st_d      = st_q >> BYTE_W;
						cnt_d     = cnt_q + 1'b1;
						if (emit_last) begin
							state_d = ST_DIV;
							rem_d   = '0;
							cnt_d   = '0;
						end
					end else begin
						// no byte needed: empty closing beat
						emit_last = 1'b1;
						state_d   = ST_DIV;
						rem_d     = '0;
						cnt_d     = '0;
					end
				end
			end

			ST_DIV: begin
				rem_d = FREQ_W'(part - sub);
				st_d  = {st_q[STATE_W-DIGIT_W-1:0], digit};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIX;
					cnt_d   = '0;
				end
			end

			ST_FIX: begin
				// x = (q << PROB_BITS) + r + c, modulo 2^32
				st_d    = (st_q << PROB_BITS) + STATE_W'(rem_q) + STATE_W'(entry.cum);
				state_d = ST_IDLE;
			end

			ST_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_byte = st_q[BYTE_W-1:0];
					emit_bv   = 1'b1;
					emit_last = (cnt_q == CNT_W'(FLUSH_BYTES - 1));
					st_d      = st_q >> BYTE_W;
					cnt_d     = cnt_q + 1'b1;
					if (emit_last) begin
						st_d    = LOWER_BOUND;
						cnt_d   = '0;
						state_d = ST_IDLE;
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_byte_q <= emit_byte;
			res_bv_q   <= emit_bv;
			res_err_q  <= emit_err;
			res_last_q <= emit_last;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_byte   = res_byte_q;
	assign result.byte_valid = res_bv_q;
	assign result.error      = res_err_q;
	assign result.last       = res_last_q;

endmodule

[rtl/core/rbe_checker.sv]
module rbe_checker import rbe_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [1:0]        cmd_operation,
	input logic              res_valid,
	input logic              res_ready,
	input logic [BYTE_W-1:0] res_out_byte,
	input logic              res_byte_valid,
	input logic              res_error,
	input logic              res_last
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
			&& $stable(res_byte_valid) && $stable(res_error) && $stable(res_last))
		else $error("result beat dropped or changed while stalled");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error |-> res_last && !res_byte_valid)
		else $error("error beat must be a lone closing beat without byte");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_byte_valid |-> res_last)
		else $error("beat without byte must close its command");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (op_t'(cmd_operation) == OP_ENCODE || op_t'(cmd_operation) == OP_FLUSH)
			|=> !cmd_ready)
		else $error("encoder took a command while still busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && op_t'(cmd_operation) == OP_LOAD |=> cmd_ready)
		else $error("table load stalled the command channel");

endmodule

bind rans_byte_encoder rbe_checker u_rbe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_operation  (cmd.operation),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_out_byte   (result.out_byte),
	.res_byte_valid (result.byte_valid),
	.res_error      (result.error),
	.res_last       (result.last)
);
